### sv/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

    // calibration register indexes
    localparam logic [2:0] CfgTemp   = 3'd0;
    localparam logic [2:0] CfgPressA = 3'd1;
    localparam logic [2:0] CfgPressB = 3'd2;
    localparam logic [2:0] CfgPressC = 3'd3;

    // divider geometry
    localparam int DivSteps = 64;
    localparam int DivisorW = 31;

    // fixed constants of the compensation formula
    localparam logic [20:0] PressOffset = 21'd1048576;
    localparam logic [11:0] PressScale  = 12'd3125;
    localparam logic signed [28:0] TempRound = 29'sd128;
    localparam logic signed [26:0] FineBias  = 27'sd128000;
    localparam logic [63:0] OneQ47 = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_calib;

    typedef struct packed {
        logic [63:0]         mag_a;
        logic [DivisorW-1:0] mag_d;
        logic                qneg;
        logic                dz;
        logic [31:0]         temp;
    } t_div_req;

    typedef struct packed {
        logic [63:0] quot;
        logic        qneg;
        logic        dz;
        logic [31:0] temp;
    } t_div_rsp;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] pres;
        logic        dz;
    } t_result;

endpackage
`default_nettype wire

### sv/bsc_front.sv
`default_nettype none
module bsc_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  wire  [19:0]        i_adc_t,
    input  wire  [19:0]        i_adc_p,
    input  bsc_pkg::t_calib    i_cal,
    output logic               o_valid,
    output bsc_pkg::t_div_req  o_req
);
    import bsc_pkg::*;

    logic [10:0] r_vld;

    // stage 1: temperature differences and first products
    logic signed [18:0] n1_d1;
    logic signed [17:0] n1_d2;
    logic signed [35:0] n1_sq;
    logic signed [34:0] r1_pa;
    logic [31:0]        r1_sq;
    logic [19:0]        r1_adcp;

    // stage 2
    logic signed [36:0] n2_pb;
    logic signed [23:0] r2_va;
    logic signed [36:0] r2_pb;
    logic [19:0]        r2_adcp;

    // stage 3: fine temperature
    logic signed [25:0] r3_tf;
    logic [19:0]        r3_adcp;

    // stage 4: temperature output and pressure offset
    logic signed [28:0] n4_t5;
    logic signed [25:0] w4_tf;
    logic [31:0]        r4_temp;
    logic signed [26:0] r4_v1;
    logic [19:0]        r4_adcp;

    // stage 5
    logic signed [53:0] r5_vsq;
    logic signed [42:0] r5_m5;
    logic signed [42:0] r5_m2;
    logic [31:0]        r5_temp;
    logic [19:0]        r5_adcp;

    // stage 6: split products of the square
    logic signed [48:0] r6_a6l;
    logic signed [37:0] r6_a6h;
    logic signed [48:0] r6_a3l;
    logic signed [37:0] r6_a3h;
    logic signed [42:0] r6_m5;
    logic signed [42:0] r6_m2;
    logic [31:0]        r6_temp;
    logic [19:0]        r6_adcp;

    // stage 7
    logic [63:0]        r7_v2;
    logic [63:0]        r7_x3;
    logic signed [42:0] r7_m2;
    logic [31:0]        r7_temp;
    logic [19:0]        r7_adcp;

    // stage 8
    logic [20:0]        n8_pp;
    logic [63:0]        n8_v1b;
    logic [63:0]        r8_base;
    logic [63:0]        r8_pd;
    logic [31:0]        r8_temp;

    // stage 9
    logic [47:0]        r9_bl;
    logic [31:0]        r9_bh;
    logic [43:0]        r9_dl;
    logic [31:0]        r9_dh;
    logic [31:0]        r9_temp;

    // stage 10
    logic [63:0]        n10_bsum;
    logic [63:0]        r10_a;
    logic [30:0]        r10_d;
    logic               r10_dz;
    logic [31:0]        r10_temp;

    // stage 11
    t_div_req           r11_req;

    assign n1_d1 = $signed({2'b00, i_adc_t[19:3]}) - $signed({2'b00, i_cal.t1, 1'b0});
    assign n1_d2 = $signed({2'b00, i_adc_t[19:4]}) - $signed({2'b00, i_cal.t1});
    assign n1_sq = n1_d2 * n1_d2;
    assign n2_pb = $signed({1'b0, r1_sq[31:12]}) * $signed(i_cal.t3);
    assign w4_tf = r3_tf;
    assign n4_t5 = ($signed({{3{w4_tf[25]}}, w4_tf}) <<< 2)
                 + $signed({{3{w4_tf[25]}}, w4_tf}) + TempRound;
    assign n8_pp  = PressOffset - {1'b0, r7_adcp};
    assign n8_v1b = {{8{r7_x3[63]}}, r7_x3[63:8]} + {{9{r7_m2[42]}}, r7_m2, 12'b0};
    assign n10_bsum = {16'b0, r9_bl} + {r9_bh, 32'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[9:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pa   <= n1_d1 * $signed(i_cal.t2);
            r1_sq   <= n1_sq[31:0];
            r1_adcp <= i_adc_p;

            r2_va   <= r1_pa[34:11];
            r2_pb   <= n2_pb;
            r2_adcp <= r1_adcp;

            r3_tf   <= {{2{r2_va[23]}}, r2_va} + {{3{r2_pb[36]}}, r2_pb[36:14]};
            r3_adcp <= r2_adcp;

            r4_temp <= {{11{n4_t5[28]}}, n4_t5[28:8]};
            r4_v1   <= $signed({w4_tf[25], w4_tf}) - FineBias;
            r4_adcp <= r3_adcp;

            r5_vsq  <= r4_v1 * r4_v1;
            r5_m5   <= r4_v1 * $signed(i_cal.p5);
            r5_m2   <= r4_v1 * $signed(i_cal.p2);
            r5_temp <= r4_temp;
            r5_adcp <= r4_adcp;

            r6_a6l  <= $signed({1'b0, r5_vsq[31:0]}) * $signed(i_cal.p6);
            r6_a6h  <= $signed(r5_vsq[53:32]) * $signed(i_cal.p6);
            r6_a3l  <= $signed({1'b0, r5_vsq[31:0]}) * $signed(i_cal.p3);
            r6_a3h  <= $signed(r5_vsq[53:32]) * $signed(i_cal.p3);
            r6_m5   <= r5_m5;
            r6_m2   <= r5_m2;
            r6_temp <= r5_temp;
            r6_adcp <= r5_adcp;

            r7_v2   <= {{15{r6_a6l[48]}}, r6_a6l} + {r6_a6h[31:0], 32'b0}
                     + {{4{r6_m5[42]}}, r6_m5, 17'b0}
                     + {{13{i_cal.p4[15]}}, i_cal.p4, 35'b0};
            r7_x3   <= {{15{r6_a3l[48]}}, r6_a3l} + {r6_a3h[31:0], 32'b0};
            r7_m2   <= r6_m2;
            r7_temp <= r6_temp;
            r7_adcp <= r6_adcp;

            r8_base <= n8_v1b + OneQ47;
            r8_pd   <= {12'b0, n8_pp, 31'b0} - r7_v2;
            r8_temp <= r7_temp;

            r9_bl   <= r8_base[31:0] * i_cal.p1;
            r9_bh   <= r8_base[63:32] * {16'b0, i_cal.p1};
            r9_dl   <= r8_pd[31:0] * PressScale;
            r9_dh   <= r8_pd[63:32] * {20'b0, PressScale};
            r9_temp <= r8_temp;

            r10_a    <= {20'b0, r9_dl} + {r9_dh, 32'b0};
            r10_d    <= n10_bsum[63:33];
            r10_dz   <= (n10_bsum[63:33] == '0);
            r10_temp <= r9_temp;

            // magnitudes for the unsigned divider
            r11_req.mag_a <= r10_a[63] ? (64'd0 - r10_a) : r10_a;
            r11_req.mag_d <= r10_d[30] ? (31'd0 - r10_d) : r10_d;
            r11_req.qneg  <= r10_a[63] ^ r10_d[30];
            r11_req.dz    <= r10_dz;
            r11_req.temp  <= r10_temp;
        end
    end

    assign o_valid = r_vld[10];
    assign o_req   = r11_req;

endmodule
`default_nettype wire

### sv/bsc_div.sv
`default_nettype none
module bsc_div (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  bsc_pkg::t_div_req  i_req,
    output logic               o_valid,
    output bsc_pkg::t_div_rsp  o_rsp
);
    import bsc_pkg::*;

    // one quotient bit per stage, restoring form
    logic [DivisorW-1:0] r_rem  [DivSteps];
    logic [63:0]         r_qd   [DivSteps];
    logic [DivisorW-1:0] r_dd   [DivSteps];
    logic                r_qneg [DivSteps];
    logic                r_dz   [DivSteps];
    logic [31:0]         r_temp [DivSteps];
    logic [DivSteps-1:0] r_vld;

    for (genvar k = 0; k < DivSteps; k++) begin : g_step
        logic [DivisorW-1:0] w_rem;
        logic [63:0]         w_qd;
        logic [DivisorW-1:0] w_dd;
        logic                w_qneg;
        logic                w_dz;
        logic [31:0]         w_temp;
        logic                w_vld;
        logic [DivisorW:0]   w_sh;
        logic [DivisorW:0]   w_diff;
        logic                w_ge;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_qd   = i_req.mag_a;
            assign w_dd   = i_req.mag_d;
            assign w_qneg = i_req.qneg;
            assign w_dz   = i_req.dz;
            assign w_temp = i_req.temp;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_qd   = r_qd[k-1];
            assign w_dd   = r_dd[k-1];
            assign w_qneg = r_qneg[k-1];
            assign w_dz   = r_dz[k-1];
            assign w_temp = r_temp[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_sh   = {w_rem, w_qd[63]};
        assign w_ge   = (w_sh >= {1'b0, w_dd});
        assign w_diff = w_sh - {1'b0, w_dd};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DivisorW-1:0] : w_sh[DivisorW-1:0];
                r_qd[k]   <= {w_qd[62:0], w_ge};
                r_dd[k]   <= w_dd;
                r_qneg[k] <= w_qneg;
                r_dz[k]   <= w_dz;
                r_temp[k] <= w_temp;
            end
        end
    end

    assign o_valid    = r_vld[DivSteps-1];
    assign o_rsp.quot = r_qd[DivSteps-1];
    assign o_rsp.qneg = r_qneg[DivSteps-1];
    assign o_rsp.dz   = r_dz[DivSteps-1];
    assign o_rsp.temp = r_temp[DivSteps-1];

endmodule
`default_nettype wire

### sv/bsc_back.sv
`default_nettype none
module bsc_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire                i_valid,
    input  bsc_pkg::t_div_rsp  i_rsp,
    input  bsc_pkg::t_calib    i_cal,
    output logic               o_valid,
    output bsc_pkg::t_result   o_res
);
    import bsc_pkg::*;

    logic [5:0] r_vld;
    logic [31:0] r_temp [6];
    logic        r_dz   [6];

    // stage a: signed quotient
    logic [63:0] ra_p;

    // stage b: square and p8 products
    logic [63:0] nb_ps;
    logic [63:0] rb_aa;
    logic [31:0] rb_ah;
    logic signed [48:0] rb_w2l;
    logic [31:0] rb_w2h;
    logic [63:0] rb_p;

    // stage c
    logic [63:0] nc_w2;
    logic [63:0] rc_sq;
    logic [63:0] rc_w2;
    logic [63:0] rc_p;

    // stage d: p9 products
    logic signed [48:0] rd_w1l;
    logic [31:0] rd_w1h;
    logic [63:0] rd_w2;
    logic [63:0] rd_p;

    // stage e
    logic [63:0] ne_w1;
    logic [63:0] re_w1;
    logic [63:0] re_w2;
    logic [63:0] re_p;

    // stage f: sum
    logic [63:0] rf_s;

    // output stage, registered by the caller
    logic [63:0] ng_f;

    assign nb_ps = {{13{ra_p[63]}}, ra_p[63:13]};
    assign nc_w2 = {{15{rb_w2l[48]}}, rb_w2l} + {rb_w2h, 32'b0};
    assign ne_w1 = {{15{rd_w1l[48]}}, rd_w1l} + {rd_w1h, 32'b0};
    assign ng_f  = {{8{rf_s[63]}}, rf_s[63:8]} + {{44{i_cal.p7[15]}}, i_cal.p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_temp[0] <= i_rsp.temp;
            r_dz[0]   <= i_rsp.dz;
            for (int k = 1; k < 6; k++) begin
                r_temp[k] <= r_temp[k-1];
                r_dz[k]   <= r_dz[k-1];
            end

            ra_p   <= i_rsp.qneg ? (64'd0 - i_rsp.quot) : i_rsp.quot;

            rb_aa  <= nb_ps[31:0] * nb_ps[31:0];
            rb_ah  <= nb_ps[63:32] * nb_ps[31:0];
            rb_w2l <= $signed({1'b0, ra_p[31:0]}) * $signed(i_cal.p8);
            rb_w2h <= ra_p[63:32] * {{16{i_cal.p8[15]}}, i_cal.p8};
            rb_p   <= ra_p;

            // cross term appears twice, hence the shift by 33
            rc_sq  <= rb_aa + {rb_ah[30:0], 33'b0};
            rc_w2  <= {{19{nc_w2[63]}}, nc_w2[63:19]};
            rc_p   <= rb_p;

            rd_w1l <= $signed({1'b0, rc_sq[31:0]}) * $signed(i_cal.p9);
            rd_w1h <= rc_sq[63:32] * {{16{i_cal.p9[15]}}, i_cal.p9};
            rd_w2  <= rc_w2;
            rd_p   <= rc_p;

            re_w1  <= {{25{ne_w1[63]}}, ne_w1[63:25]};
            re_w2  <= rd_w2;
            re_p   <= rd_p;

            rf_s   <= re_p + re_w1 + re_w2;
        end
    end

    always_comb begin
        o_res.temp = r_temp[5];
        o_res.dz   = r_dz[5];
        if (r_dz[5] || ng_f[63]) begin
            o_res.pres = '0;
        end else if (|ng_f[62:32]) begin
            o_res.pres = '1;
        end else begin
            o_res.pres = ng_f[31:0];
        end
    end

    assign o_valid = r_vld[5];

endmodule
`default_nettype wire

### sv/barometric_sensor_compensation.sv
`default_nettype none
// Integer compensation for a barometric pressure/temperature sensor. Each
// transaction carries one raw 20-bit temperature and one raw 20-bit pressure
// reading; it returns the temperature in hundredths of a degree, the pressure
// in pascal as unsigned Q24.8 (clamped to 0 and to all ones) and a flag set
// when the pressure divisor came out zero, in which case pressure reads 0.
// Calibration words T1..T3 and P1..P9 are written through the register port
// (index 0: T words, 1: P1..P4, 2: P5..P8, 3: P9); the user must write them
// only while no transaction is in flight, which the block does not enforce.
// The datapath is a fixed pipeline that takes a new reading pair every clock
// cycle while the skid entry is empty. Its depth is set by the 64-stage
// bit-per-cycle unsigned divider plus eleven stages of calibration products
// ahead of it and six after. An output register with a one-entry skid
// buffer keeps input ready independent of output ready. While the output
// side stalls, the pipeline keeps moving and accepting transactions until
// the next result reaches its end; that result is parked in the skid entry
// and from the following cycle the input and the whole pipeline hold until
// the output register frees up. Nothing is dropped or repeated.
module barometric_sensor_compensation (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // calibration write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    // reading transactions
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [19:0] i_adc_temperature,
    input  wire  [19:0] i_adc_pressure,
    // result transactions
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_divide_by_zero
);
    import bsc_pkg::*;

    // calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_a;
    logic [63:0] r_cal_b;
    logic [15:0] r_cal_c;
    t_calib      w_cal;

    // pipeline hookup
    logic        w_en;
    logic        w_div_in_vld;
    t_div_req    w_div_req;
    logic        w_div_out_vld;
    t_div_rsp    w_div_rsp;
    logic        w_res_vld;
    t_result     w_res;

    // output register and skid entry
    logic        r_out_vld;
    logic        r_skid_vld;
    t_result     r_out;
    t_result     r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t <= '0;
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgTemp:   r_cal_t <= i_cfg_data[47:0];
                CfgPressA: r_cal_a <= i_cfg_data;
                CfgPressB: r_cal_b <= i_cfg_data;
                CfgPressC: r_cal_c <= i_cfg_data[15:0];
                default:   ; // unused index, write dropped
            endcase
        end
    end

    // unpack the packed calibration words
    assign w_cal.t1 = r_cal_t[15:0];
    assign w_cal.t2 = r_cal_t[31:16];
    assign w_cal.t3 = r_cal_t[47:32];
    assign w_cal.p1 = r_cal_a[15:0];
    assign w_cal.p2 = r_cal_a[31:16];
    assign w_cal.p3 = r_cal_a[47:32];
    assign w_cal.p4 = r_cal_a[63:48];
    assign w_cal.p5 = r_cal_b[15:0];
    assign w_cal.p6 = r_cal_b[31:16];
    assign w_cal.p7 = r_cal_b[47:32];
    assign w_cal.p8 = r_cal_b[63:48];
    assign w_cal.p9 = r_cal_c;

    // the whole pipeline advances together unless the skid entry is occupied
    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_adc_t (i_adc_temperature),
        .i_adc_p (i_adc_pressure),
        .i_cal   (w_cal),
        .o_valid (w_div_in_vld),
        .o_req   (w_div_req)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_in_vld),
        .i_req   (w_div_req),
        .o_valid (w_div_out_vld),
        .o_rsp   (w_div_rsp)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_out_vld),
        .i_rsp   (w_div_rsp),
        .i_cal   (w_cal),
        .o_valid (w_res_vld),
        .o_res   (w_res)
    );

    // output register control: refill from skid first, else from pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_res_vld;
            end
        end else if (w_res_vld && w_en) begin
            // output stalled: park the arriving result
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_res_vld && w_en) begin
            r_skid <= w_res;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_temperature_centi = r_out.temp;
    assign o_pressure_q24_8    = r_out.pres;
    assign o_divide_by_zero    = r_out.dz;

endmodule
`default_nettype wire

### sv/bsc_checker.sv
`default_nettype none
module bsc_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_ready,
    input wire         o_valid,
    input wire         i_ready,
    input wire  [31:0] o_temperature_centi,
    input wire  [31:0] o_pressure_q24_8,
    input wire         o_divide_by_zero
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pressure_q24_8)
            && $stable(o_temperature_centi) && $stable(o_divide_by_zero))
        else $error("result changed while stalled");

    // zero divisor forces zero pressure
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_pressure_q24_8 == 32'd0)
        else $error("pressure nonzero with divide by zero flag");

    // reset empties the output side and reopens the input
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("output or skid not cleared by reset");

    // input side only closes when a result is held back
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid) && !$past(i_ready))
        else $error("input stalled without output back pressure");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (.*);
`default_nettype wire
